### hdl/btffa_pkg.sv
// Shared definitions of the boundary-tag first-fit allocator.
// Holds the controller state type, request codes and default sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btffa_pkg;

  localparam int DEF_HEAP_BYTES  = 65536;
  localparam int DEF_CHUNK_BYTES = 4096;
  localparam int MIN_BLOCK       = 16;
  localparam int TAG_WIDTH       = 32;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIT_RD,
    ST_FIT_CHK,
    ST_GROW,
    ST_GROW_W1,
    ST_GROW_W2,
    ST_M_RD0,
    ST_M_RD1,
    ST_M_RD2,
    ST_M_CALC,
    ST_M_W1,
    ST_C_RD,
    ST_C_CHK,
    ST_C_W1,
    ST_C_W2,
    ST_C_W3,
    ST_F_RD,
    ST_F_HDR,
    ST_F_FTR,
    ST_F_W1,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

### hdl/btffa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; used for the heap word store.
`timescale 1ns / 1ps
`default_nettype none

module btffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/boundary_tag_first_fit_allocator_unit.sv
// Top level of the boundary-tag first-fit heap allocator.
// Depends on btffa_pkg and btffa_ram (the heap word store).
//
// Usage: one request word enters on the input channel (in_valid_i, in_stall_o) and
// one result word leaves on the output channel (out_valid_o, out_stall_i). A word
// moves at a rising edge where valid is high and stall is low. A request either
// allocates req_size_i payload bytes or frees the block whose payload starts at
// req_addr_i; the result gives the payload offset (or the echoed address) and ok_o.
// After reset the block sweeps the whole heap store, one word per cycle, writing
// zeros and the initial prologue, free chunk and epilogue; in_stall_o stays high
// during the sweep. Requests are handled one at a time by a read-modify-write
// sequencer around a single memory with a registered read port.
// An allocate reads one header per heap block visited by the first-fit walk, then
// ends the walk, grows the heap and coalesces when needed, splits and loads the result.
// A valid free checks header and footer, frees both tags, coalesces and loads the
// result register, and the sequencer then returns to idle for the next request.
// The walk over the memory read port sets the rate, so it falls as the heap fills.
// Results wait in an output register; while the receiver stalls, the next request
// is still accepted and processed, and it waits only to load that register.
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_first_fit_allocator_unit #(
  parameter int HEAP_BYTES  = btffa_pkg::DEF_HEAP_BYTES,
  parameter int CHUNK_BYTES = btffa_pkg::DEF_CHUNK_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [15:0] req_size_i,
  input  wire logic [15:0] req_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [15:0] block_addr_o,
  output logic             ok_o
);

  // Byte addresses and sizes are carried at AW bits: wide enough for the heap
  // end plus a grown chunk, and for the 16-bit request fields.
  localparam int AW    = (($clog2(HEAP_BYTES) + 2) > 18) ? ($clog2(HEAP_BYTES) + 2) : 18;
  localparam int WORDS = HEAP_BYTES / 4;
  localparam int IW    = $clog2(WORDS);
  localparam int TW    = btffa_pkg::TAG_WIDTH;
  localparam int CB    = ((CHUNK_BYTES + 7) / 8) * 8;

  // The initial chunk sits right after the prologue when it fits.
  localparam bit INIT_OK  = (16 + CB) <= HEAP_BYTES;
  localparam int IDX_FTR  = (16 + CB - 8) / 4;
  localparam int IDX_EPI  = (16 + CB - 4) / 4;
  localparam int END_RST  = INIT_OK ? (16 + CB) : 16;

  localparam logic [AW-1:0] SZ_MASK = ~AW'(7);
  localparam logic [AW-1:0] C_W     = AW'(CB);
  localparam logic [AW-1:0] HB_W    = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] MIN_W   = AW'(btffa_pkg::MIN_BLOCK);
  localparam logic [TW-1:0] PRO_TAG = TW'(9);
  localparam logic [TW-1:0] EPI_TAG = TW'(1);

  function automatic logic [IW-1:0] widx(input logic [AW-1:0] a);
    return a[IW+1:2];
  endfunction

  function automatic logic [TW-1:0] tag(input logic [AW-1:0] sz, input logic used);
    return TW'(sz) | TW'(used);
  endfunction

  function automatic logic [TW-1:0] init_word(input logic [IW-1:0] i);
    logic [TW-1:0] w;
    w = '0;
    if (i == IW'(1) || i == IW'(2)) begin
      w = PRO_TAG;
    end else if (i == IW'(3)) begin
      w = INIT_OK ? tag(C_W, 1'b0) : EPI_TAG;
    end else if (INIT_OK && i == IW'(IDX_FTR)) begin
      w = tag(C_W, 1'b0);
    end else if (INIT_OK && i == IW'(IDX_EPI)) begin
      w = EPI_TAG;
    end
    return w;
  endfunction

  btffa_pkg::state_e state_q, state_d;

  logic [IW-1:0] clr_q, clr_d;
  logic [AW-1:0] heap_end_q, heap_end_d;
  logic [AW-1:0] p_q, p_d;
  logic [AW-1:0] sz_q, sz_d;
  logic [AW-1:0] need_q, need_d;
  logic [AW-1:0] psz_q, psz_d;
  logic [AW-1:0] have_q, have_d;
  logic          prev_free_q, prev_free_d;
  logic          split_q, split_d;
  logic          is_free_q, is_free_d;
  logic [TW-1:0] h_q, h_d;
  logic [15:0]   res_addr_q, res_addr_d;
  logic          res_ok_q, res_ok_d;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   out_addr_q, out_addr_d;
  logic          out_ok_q, out_ok_d;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [TW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [TW-1:0] mem_rdata;

  btffa_ram #(
    .WIDTH (TW),
    .DEPTH (WORDS)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  logic [AW-1:0] rd_size;
  logic          rd_used;
  logic          in_acc;
  logic [AW-1:0] grow_bytes;
  logic [AW-1:0] merged_sz;
  logic [AW-1:0] merged_p;
  logic [AW-1:0] nsz;
  logic          next_free;

  assign rd_size = mem_rdata[AW-1:0] & SZ_MASK;
  assign rd_used = mem_rdata[0];
  assign in_acc  = in_valid_i && !in_stall_o;

  assign in_stall_o   = (state_q != btffa_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign block_addr_o = out_addr_q;
  assign ok_o         = out_ok_q;

  assign grow_bytes = (need_q > C_W) ? need_q : C_W;
  assign nsz        = rd_size;
  assign next_free  = !rd_used && (nsz != '0);
  assign merged_sz  = sz_q + (next_free ? nsz : '0) + (prev_free_q ? psz_q : '0);
  assign merged_p   = p_q - (prev_free_q ? psz_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btffa_pkg::ST_CLEAR;
      clr_q       <= '0;
      heap_end_q  <= AW'(END_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      heap_end_q  <= heap_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    sz_q        <= sz_d;
    need_q      <= need_d;
    psz_q       <= psz_d;
    have_q      <= have_d;
    prev_free_q <= prev_free_d;
    split_q     <= split_d;
    is_free_q   <= is_free_d;
    h_q         <= h_d;
    res_addr_q  <= res_addr_d;
    res_ok_q    <= res_ok_d;
    out_addr_q  <= out_addr_d;
    out_ok_q    <= out_ok_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    heap_end_d  = heap_end_q;
    p_d         = p_q;
    sz_d        = sz_q;
    need_d      = need_q;
    psz_d       = psz_q;
    have_d      = have_q;
    prev_free_d = prev_free_q;
    split_d     = split_q;
    is_free_d   = is_free_q;
    h_d         = h_q;
    res_addr_d  = res_addr_q;
    res_ok_d    = res_ok_q;
    out_addr_d  = out_addr_q;
    out_ok_d    = out_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;

    case (state_q)
      btffa_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = init_word(clr_q);
        if (clr_q == IW'(WORDS - 1)) begin
          state_d = btffa_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + IW'(1);
        end
      end

      btffa_pkg::ST_IDLE: begin
        if (in_acc) begin
          is_free_d  = (req_type_i == btffa_pkg::REQ_FREE);
          res_ok_d   = 1'b0;
          if (req_type_i == btffa_pkg::REQ_FREE) begin
            res_addr_d = req_addr_i;
            p_d        = AW'(req_addr_i);
            state_d    = btffa_pkg::ST_F_RD;
          end else begin
            res_addr_d = '0;
            p_d        = AW'(8);
            if (req_size_i <= 16'd8) begin
              need_d = MIN_W;
            end else begin
              need_d = (AW'(req_size_i) + AW'(15)) & SZ_MASK;
            end
            state_d = (req_size_i == '0) ? btffa_pkg::ST_RESP : btffa_pkg::ST_FIT_RD;
          end
        end
      end

      // First-fit walk: one header read per visited block.
      btffa_pkg::ST_FIT_RD: begin
        if (p_q >= heap_end_q) begin
          state_d = btffa_pkg::ST_GROW;
        end else begin
          mem_raddr = widx(p_q - AW'(4));
          state_d   = btffa_pkg::ST_FIT_CHK;
        end
      end

      btffa_pkg::ST_FIT_CHK: begin
        if (rd_size == '0) begin
          state_d = btffa_pkg::ST_GROW;
        end else if (!rd_used && need_q <= rd_size) begin
          state_d = btffa_pkg::ST_C_RD;
        end else begin
          p_d     = p_q + rd_size;
          state_d = btffa_pkg::ST_FIT_RD;
        end
      end

      btffa_pkg::ST_GROW: begin
        if (grow_bytes > HB_W || (heap_end_q + grow_bytes) > HB_W) begin
          state_d = btffa_pkg::ST_RESP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = widx(heap_end_q - AW'(4));
          mem_wdata = tag(grow_bytes, 1'b0);
          p_d       = heap_end_q;
          sz_d      = grow_bytes;
          state_d   = btffa_pkg::ST_GROW_W1;
        end
      end

      btffa_pkg::ST_GROW_W1: begin
        mem_we    = 1'b1;
        mem_waddr = widx(p_q + sz_q - AW'(8));
        mem_wdata = tag(sz_q, 1'b0);
        state_d   = btffa_pkg::ST_GROW_W2;
      end

      btffa_pkg::ST_GROW_W2: begin
        mem_we     = 1'b1;
        mem_waddr  = widx(p_q + sz_q - AW'(4));
        mem_wdata  = EPI_TAG;
        heap_end_d = p_q + sz_q;
        state_d    = btffa_pkg::ST_M_RD0;
      end

      // Coalescing: read own header, previous footer and next header.
      btffa_pkg::ST_M_RD0: begin
        mem_raddr = widx(p_q - AW'(4));
        state_d   = btffa_pkg::ST_M_RD1;
      end

      btffa_pkg::ST_M_RD1: begin
        sz_d      = rd_size;
        mem_raddr = widx(p_q - AW'(8));
        state_d   = btffa_pkg::ST_M_RD2;
      end

      btffa_pkg::ST_M_RD2: begin
        psz_d       = rd_size;
        prev_free_d = !rd_used && rd_size >= MIN_W && rd_size <= (p_q - AW'(8));
        mem_raddr   = widx(p_q + sz_q - AW'(4));
        state_d     = btffa_pkg::ST_M_CALC;
      end

      btffa_pkg::ST_M_CALC: begin
        mem_we    = 1'b1;
        mem_waddr = widx(merged_p - AW'(4));
        mem_wdata = tag(merged_sz, 1'b0);
        p_d       = merged_p;
        sz_d      = merged_sz;
        state_d   = btffa_pkg::ST_M_W1;
      end

      btffa_pkg::ST_M_W1: begin
        mem_we    = 1'b1;
        mem_waddr = widx(p_q + sz_q - AW'(8));
        mem_wdata = tag(sz_q, 1'b0);
        if (is_free_q) begin
          res_ok_d = 1'b1;
          state_d  = btffa_pkg::ST_RESP;
        end else begin
          state_d  = btffa_pkg::ST_C_RD;
        end
      end

      // Carve the allocation out of the chosen free block.
      btffa_pkg::ST_C_RD: begin
        mem_raddr = widx(p_q - AW'(4));
        state_d   = btffa_pkg::ST_C_CHK;
      end

      btffa_pkg::ST_C_CHK: begin
        have_d    = rd_size;
        split_d   = (rd_size - need_q) >= MIN_W;
        mem_we    = 1'b1;
        mem_waddr = widx(p_q - AW'(4));
        if ((rd_size - need_q) >= MIN_W) begin
          mem_wdata = tag(need_q, 1'b1);
          state_d   = btffa_pkg::ST_C_W1;
        end else begin
          mem_wdata = tag(rd_size, 1'b1);
          state_d   = btffa_pkg::ST_C_W3;
        end
      end

      btffa_pkg::ST_C_W1: begin
        mem_we    = 1'b1;
        mem_waddr = widx(p_q + need_q - AW'(8));
        mem_wdata = tag(need_q, 1'b1);
        state_d   = btffa_pkg::ST_C_W2;
      end

      btffa_pkg::ST_C_W2: begin
        mem_we    = 1'b1;
        mem_waddr = widx(p_q + need_q - AW'(4));
        mem_wdata = tag(have_q - need_q, 1'b0);
        state_d   = btffa_pkg::ST_C_W3;
      end

      btffa_pkg::ST_C_W3: begin
        mem_we     = 1'b1;
        mem_waddr  = widx(p_q + have_q - AW'(8));
        mem_wdata  = split_q ? tag(have_q - need_q, 1'b0) : tag(have_q, 1'b1);
        res_addr_d = p_q[15:0];
        res_ok_d   = 1'b1;
        state_d    = btffa_pkg::ST_RESP;
      end

      // Free: validate address, header and footer before releasing.
      btffa_pkg::ST_F_RD: begin
        if (p_q[2:0] == 3'd0 && p_q >= MIN_W && p_q < heap_end_q) begin
          mem_raddr = widx(p_q - AW'(4));
          state_d   = btffa_pkg::ST_F_HDR;
        end else begin
          state_d   = btffa_pkg::ST_RESP;
        end
      end

      btffa_pkg::ST_F_HDR: begin
        if (rd_used && rd_size >= MIN_W && (p_q + rd_size) <= heap_end_q) begin
          h_d       = mem_rdata;
          sz_d      = rd_size;
          mem_raddr = widx(p_q + rd_size - AW'(8));
          state_d   = btffa_pkg::ST_F_FTR;
        end else begin
          state_d   = btffa_pkg::ST_RESP;
        end
      end

      btffa_pkg::ST_F_FTR: begin
        if (mem_rdata == h_q) begin
          mem_we    = 1'b1;
          mem_waddr = widx(p_q - AW'(4));
          mem_wdata = tag(sz_q, 1'b0);
          state_d   = btffa_pkg::ST_F_W1;
        end else begin
          state_d   = btffa_pkg::ST_RESP;
        end
      end

      btffa_pkg::ST_F_W1: begin
        mem_we    = 1'b1;
        mem_waddr = widx(p_q + sz_q - AW'(8));
        mem_wdata = tag(sz_q, 1'b0);
        state_d   = btffa_pkg::ST_M_RD0;
      end

      btffa_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_ok_d    = res_ok_q;
          state_d     = btffa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = btffa_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // A successful result always names an 8-byte aligned payload.
  a_ok_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ok_o |-> block_addr_o[2:0] == 3'd0)
    else $error("successful result with misaligned payload address");

  // The heap end stays aligned and inside the heap.
  a_heap_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_end_q <= HB_W && heap_end_q[2:0] == 3'd0)
    else $error("heap end out of range or misaligned");

  // Once a request is taken the sequencer is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken without entering the sequencer");

  // A new result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_addr_o) && $stable(ok_o))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

### tb/boundary_tag_first_fit_allocator_unit_tb.sv
// Self-checking testbench of the boundary-tag first-fit heap allocator.
// Depends on btffa_pkg and the allocator RTL; drives allocate and free words and checks results.
`timescale 1ns / 1ps

module boundary_tag_first_fit_allocator_unit_tb;

  localparam int HEAP_B  = btffa_pkg::DEF_HEAP_BYTES;
  localparam int CHUNK_B = btffa_pkg::DEF_CHUNK_BYTES;
  localparam int WORDS   = HEAP_B / 4;
  localparam int MIN_B   = btffa_pkg::MIN_BLOCK;

  typedef struct packed {
    logic        kind;
    logic [15:0] size;
    logic [15:0] addr;
  } req_t;

  typedef struct packed {
    logic [15:0] addr;
    logic        ok;
  } res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [15:0] req_size;
  logic [15:0] req_addr;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] block_addr;
  logic        ok;

  boundary_tag_first_fit_allocator_unit u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .req_size_i   (req_size),
    .req_addr_i   (req_addr),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .block_addr_o (block_addr),
    .ok_o         (ok)
  );

  // Shadow heap, kept in the same byte layout as the block's store.
  logic [31:0] heap_mem [WORDS];
  logic [31:0] heap_top;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   live_blocks[$];   // payload offsets currently allocated, fed to frees
  int   errors;
  bit   in_taken;         // the driven word was accepted at the last rising edge

  function automatic logic [31:0] mem_rd(logic [31:0] a);
    return heap_mem[(a >> 2) % WORDS];
  endfunction

  task automatic mem_wr(logic [31:0] a, logic [31:0] v);
    heap_mem[(a >> 2) % WORDS] = v;
  endtask

  // Coalesce a free block with its free neighbors, covering all four cases.
  task automatic coalesce(logic [31:0] p);
    logic [31:0] sz, pf, psz, nh, nsz;
    bit pfree, nfree;
    sz = mem_rd(p - 4) & ~32'h7;
    pf = mem_rd(p - 8);
    psz = pf & ~32'h7;
    pfree = !pf[0] && psz >= MIN_B && psz <= p - 8;
    nh = mem_rd(p + sz - 4);
    nsz = nh & ~32'h7;
    nfree = !nh[0] && nsz > 0;
    if (nfree) sz += nsz;
    if (pfree) begin
      sz += psz;
      p -= psz;
    end
    mem_wr(p - 4, sz);
    mem_wr(p + sz - 8, sz);
  endtask

  // Grow the heap; returns the payload of the merged free block or 0.
  task automatic grow_shadow(logic [31:0] bytes, output logic [31:0] p);
    logic [31:0] pf, psz;
    p = heap_top;
    if (bytes > HEAP_B || p + bytes > HEAP_B) begin
      p = 0;
    end else begin
      mem_wr(p - 4, bytes);
      mem_wr(p + bytes - 8, bytes);
      mem_wr(p + bytes - 4, 1);
      heap_top = p + bytes;
      // Recompute where the merged block starts, then merge.
      pf = mem_rd(p - 8);
      psz = pf & ~32'h7;
      coalesce(p);
      if (!pf[0] && psz >= MIN_B && psz <= p - 8) p -= psz;
    end
  endtask

  task automatic heap_reset();
    logic [31:0] dummy;
    for (int i = 0; i < WORDS; i++) heap_mem[i] = 0;
    mem_wr(4, 9);
    mem_wr(8, 9);
    mem_wr(12, 1);
    heap_top = 16;
    grow_shadow((CHUNK_B + 7) & ~7, dummy);
  endtask

  // Predicts the result of one request word and updates the shadow heap.
  task automatic predict_alloc(req_t r, output res_t res);
    logic [31:0] need, p, h, sz, have, chunk, a;
    bit found;
    res = '0;
    if (r.kind == btffa_pkg::REQ_ALLOC) begin
      if (r.size != 0) begin
        need = (r.size <= 8) ? MIN_B : ((r.size + 15) & ~32'h7);
        p = 8;
        found = 1'b0;
        while (!found && p < heap_top) begin
          h = mem_rd(p - 4);
          sz = h & ~32'h7;
          if (sz == 0) break;
          if (!h[0] && need <= sz) found = 1'b1;
          else p += sz;
        end
        if (!found) p = 0;
        if (p == 0) begin
          chunk = (CHUNK_B + 7) & ~7;
          grow_shadow(need > chunk ? need : chunk, p);
        end
        if (p != 0) begin
          have = mem_rd(p - 4) & ~32'h7;
          if (have - need >= MIN_B) begin
            mem_wr(p - 4, need | 1);
            mem_wr(p + need - 8, need | 1);
            mem_wr(p + need - 4, have - need);
            mem_wr(p + have - 8, have - need);
          end else begin
            mem_wr(p - 4, have | 1);
            mem_wr(p + have - 8, have | 1);
          end
          res.addr = p[15:0];
          res.ok = 1'b1;
        end
      end
    end else begin
      a = r.addr;
      res.addr = r.addr;
      if (a[2:0] == 0 && a >= 16 && a < heap_top) begin
        h = mem_rd(a - 4);
        sz = h & ~32'h7;
        if (h[0] && sz >= MIN_B && a + sz <= heap_top && mem_rd(a + sz - 8) == h) begin
          mem_wr(a - 4, sz);
          mem_wr(a + sz - 8, sz);
          coalesce(a);
          res.ok = 1'b1;
        end
      end
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety limit: the clearing sweep, then roughly a thousand walks over a busy heap.
  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Gap length: half the gaps are zero, most others are short, and a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: presents queued request words, changing inputs on the falling edge.
  int in_gap;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      req_type <= 1'b0;
      req_size <= '0;
      req_addr <= '0;
      in_gap   <= 0;
    end else if (in_valid && !in_taken) begin
      // Hold the stalled word unchanged.
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap   <= in_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      req_t r;
      r = pending_reqs.pop_front();
      in_valid <= 1'b1;
      req_type <= r.kind;
      req_size <= r.size;
      req_addr <= r.addr;
      in_gap   <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern, also changed on the falling edge.
  int stall_left;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
    end
  end

  // Accepted inputs are predicted at the rising edge; accepted results are checked.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      req_t r;
      res_t e;
      r = '{kind: req_type, size: req_size, addr: req_addr};
      predict_alloc(r, e);
      expected_results.push_back(e);
    end
    if (rst_n && out_valid && !out_stall) begin
      res_t e;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word addr=%h ok=%b", $time, block_addr, ok);
      end else begin
        e = expected_results.pop_front();
        if (e.addr !== block_addr) begin
          errors++;
          $display("%0t: block_addr expected %h actual %h", $time, e.addr, block_addr);
        end
        if (e.ok !== ok) begin
          errors++;
          $display("%0t: ok expected %b actual %b", $time, e.ok, ok);
        end
      end
    end
  end

  function automatic req_t mk_alloc(int sz);
    return '{kind: btffa_pkg::REQ_ALLOC, size: sz[15:0], addr: 16'($urandom)};
  endfunction

  function automatic req_t mk_free(int a);
    return '{kind: btffa_pkg::REQ_FREE, size: 16'($urandom), addr: a[15:0]};
  endfunction

  // Allocations are tracked by what the shadow heap will return, so frees
  // can target live blocks: the stimulus is planned on the shadow heap, which
  // is set back to its reset state before the run starts.
  task automatic plan(req_t r);
    res_t e;
    predict_alloc(r, e);
    if (r.kind == btffa_pkg::REQ_ALLOC && e.ok) live_blocks.push_back(e.addr);
    pending_reqs.push_back(r);
  endtask

  task automatic free_random_live();
    int k;
    k = $urandom_range(0, live_blocks.size() - 1);
    plan(mk_free(live_blocks[k]));
    live_blocks.delete(k);
  endtask

  initial begin
    int n, r;
    errors    = 0;
    rst_n     = 1'b0;
    heap_reset();

    // Directed: size extremes, zero size, exhaustion, and bad frees.
    plan(mk_alloc(0));
    plan(mk_alloc(1));
    plan(mk_alloc(8));
    plan(mk_alloc(9));
    plan(mk_alloc(16));
    plan(mk_alloc(4000));         // takes the rest of the initial chunk, too small to split
    plan(mk_alloc(65535));        // heap exhausted
    plan(mk_alloc(30000));
    plan(mk_alloc(30000));        // grows the heap close to its limit
    plan(mk_free(16'hFFFF));      // misaligned, at or past the end
    plan(mk_free(8));             // below the first payload
    plan(mk_free(16'hFFF8));      // past heap end
    plan(mk_free(live_blocks[1]+8)); // not a header of a live block
    plan(mk_free(live_blocks[1]));   // free then double free
    plan(mk_free(live_blocks[1]));
    plan(mk_free(live_blocks[3]));   // both neighbours in use, released without coalescing
    plan(mk_free(live_blocks[2]));   // merge on both sides
    plan(mk_free(live_blocks[0]));
    for (int i = 3; i >= 0; i--) if (i != 4) live_blocks.delete(i);
    free_random_live();
    while (live_blocks.size() > 0) free_random_live();

    // Random: mostly well-formed allocate/free traffic, some junk frees.
    n = 0;
    while (n < 1000) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        if ($urandom_range(0, 19) == 0) plan(mk_alloc($urandom_range(0, 65535)));
        else plan(mk_alloc($urandom_range(1, 600)));
      end else if (r < 90 && live_blocks.size() > 0) begin
        free_random_live();
      end else begin
        plan(mk_free($urandom_range(0, 65535)));
      end
      n++;
      if (live_blocks.size() > 60) free_random_live();
    end

    // The shadow heap starts the run from the reset state again.
    heap_reset();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_reqs.size() == 0);
    @(posedge clk);
    wait (expected_results.size() == 0 && !in_valid);
    repeat (100) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
